// ----- rtl/bmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpc_pkg
// Types, constants and arithmetic helpers shared by the barometer
// compensation core.
// ----------------------------------------------------------------------------
package bmpc_pkg;

    localparam int FRONT_STAGES = 4;
    localparam int PRE_STAGES   = 10;
    localparam int DIV_STAGES   = 64;
    localparam int POST_STAGES  = 7;
    localparam int QDEPTH       = 8;

    localparam logic [63:0] C_FINE_OFFSET = 64'd128000;
    localparam logic [63:0] C_PRESS_BASE  = 64'd1048576;
    localparam logic [63:0] C_PRESS_SCALE = 64'd3125;
    localparam logic [63:0] C_ONE_Q47     = 64'd1 << 47;

    typedef enum logic [7:0] {
        CFG_CAL_TEMPERATURE   = 8'd0,
        CFG_CAL_PRESSURE_LOW  = 8'd1,
        CFG_CAL_PRESSURE_MID  = 8'd2,
        CFG_CAL_PRESSURE_HIGH = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_low;
        logic [63:0] press_mid;
        logic [15:0] press_high;
    } cal_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [19:0] adc_press;
    } item_t;

    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } part_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] zx16(input logic [15:0] v);
        return {48'd0, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic part_t mul_part(input logic [63:0] a, input logic [63:0] b);
        part_t r;
        r.ll = a[31:0] * b[31:0];
        r.lh = 32'(a[31:0] * b[63:32]);
        r.hl = 32'(a[63:32] * b[31:0]);
        return r;
    endfunction

    function automatic logic [63:0] mul_join(input part_t p);
        logic [31:0] mid;
        mid = p.lh + p.hl;
        return p.ll + {mid, 32'd0};
    endfunction

endpackage

// ----- rtl/bmpc_front.sv -----
// ----------------------------------------------------------------------------
// bmpc_front
// Accepts reading pairs and computes the fine temperature in a short
// pipeline.
// ----------------------------------------------------------------------------
module bmpc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [19:0]         adc_temp,
    input  logic [19:0]         adc_press,
    input  bmpc_pkg::cal_t      cal,
    output logic                out_valid,
    output bmpc_pkg::item_t     out_item,
    output logic [$clog2(bmpc_pkg::FRONT_STAGES+1)-1:0] inflight
);
    import bmpc_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [17:0] x1_reg, x1_next;
    logic signed [16:0] d_reg, d_next;
    logic signed [33:0] m1_reg, m1_next;
    logic signed [33:0] dd_reg, dd_next;
    logic signed [22:0] ta_reg, ta_next;
    logic signed [37:0] m2_reg, m2_next;
    logic        [31:0] fine_reg, fine_next;
    logic [19:0] ap1_reg, ap2_reg, ap3_reg, ap4_reg;

    logic        [15:0] t1;
    logic signed [15:0] t2, t3;

    assign t1 = cal.temp[15:0];
    assign t2 = $signed(cal.temp[31:16]);
    assign t3 = $signed(cal.temp[47:32]);

    always_comb
    begin
        x1_next   = $signed({1'b0, adc_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
        d_next    = $signed({1'b0, adc_temp[19:4]}) - $signed({1'b0, t1});
        m1_next   = x1_reg * t2;
        dd_next   = d_reg * d_reg;
        ta_next   = m1_reg[33:11];
        m2_next   = $signed(dd_reg[33:12]) * t3;
        fine_next = {{9{ta_reg[22]}}, ta_reg} + {{8{m2_reg[37]}}, m2_reg[37:14]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x1_next;
        d_reg    <= d_next;
        ap1_reg  <= adc_press;
        m1_reg   <= m1_next;
        dd_reg   <= dd_next;
        ap2_reg  <= ap1_reg;
        ta_reg   <= ta_next;
        m2_reg   <= m2_next;
        ap3_reg  <= ap2_reg;
        fine_reg <= fine_next;
        ap4_reg  <= ap3_reg;
    end

    assign out_valid          = vld_reg[FRONT_STAGES-1];
    assign out_item.fine      = fine_reg;
    assign out_item.adc_press = ap4_reg;
    assign inflight = ($clog2(FRONT_STAGES+1))'($countones(vld_reg));

endmodule

// ----- rtl/bmpc_queue.sv -----
// ----------------------------------------------------------------------------
// bmpc_queue
// Short request queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module bmpc_queue
#(
    parameter int DEPTH = bmpc_pkg::QDEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  bmpc_pkg::item_t           push_item,
    output logic                      pop,
    output bmpc_pkg::item_t           pop_item,
    output logic [$clog2(DEPTH+1)-1:0] fill
);
    import bmpc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    item_t             entry_reg [DEPTH];
    logic [PW-1:0]     wr_reg, wr_next;
    logic [PW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     fill_reg, fill_next;

    assign pop      = (fill_reg != '0);
    assign pop_item = entry_reg[rd_reg];
    assign fill     = fill_reg;

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (!push && pop)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fill_reg != CW'(DEPTH)))
        else $error("queue push while full");

    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("queue fill did not advance");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (wr_reg == rd_reg))
        else $error("queue pointers differ while empty");

endmodule

// ----- rtl/bmpc_back.sv -----
// ----------------------------------------------------------------------------
// bmpc_back
// Temperature and pressure pipeline: wrapping 64-bit products, radix-2
// divider and the final correction and clamp.
// ----------------------------------------------------------------------------
module bmpc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bmpc_pkg::item_t    in_item,
    input  bmpc_pkg::cal_t     cal,
    output logic               done,
    output logic signed [23:0] temp_centi,
    output logic [31:0]        press_q8,
    output logic               press_invalid
);
    import bmpc_pkg::*;

    typedef struct packed {
        logic [23:0] tc;
        logic [63:0] a;
        logic [63:0] pm;
        logic [63:0] aa;
        logic [63:0] ap5;
        logic [63:0] ap2;
        logic [63:0] aap6;
        logic [63:0] aap3;
        logic [63:0] bb;
        logic [63:0] a2;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] q13;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] b19;
        logic [63:0] sum;
        logic [31:0] pq;
        logic        neg;
        logic        invalid;
        part_t       m0;
        part_t       m1;
        part_t       m2;
    } ctx_t;

    function automatic ctx_t div_step(input ctx_t c);
        ctx_t        r;
        logic [63:0] sh;
        r  = c;
        sh = {c.rem[62:0], c.num[63]};
        r.num = {c.num[62:0], 1'b0};
        if (sh >= c.den)
        begin
            r.rem    = sh - c.den;
            r.num[0] = 1'b1;
        end
        else
        begin
            r.rem = sh;
        end
        return r;
    endfunction

    ctx_t pre_reg  [PRE_STAGES];
    ctx_t pre_next [PRE_STAGES];
    ctx_t div_in   [DIV_STAGES];
    ctx_t div_reg  [DIV_STAGES];
    ctx_t post_reg [POST_STAGES];
    ctx_t post_next[POST_STAGES];

    logic [PRE_STAGES-1:0]  pre_vld_reg;
    logic [DIV_STAGES-1:0]  div_vld_reg;
    logic [POST_STAGES-1:0] post_vld_reg;

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign p1 = zx16(cal.press_low[15:0]);
    assign p2 = sx16(cal.press_low[31:16]);
    assign p3 = sx16(cal.press_low[47:32]);
    assign p4 = sx16(cal.press_low[63:48]);
    assign p5 = sx16(cal.press_mid[15:0]);
    assign p6 = sx16(cal.press_mid[31:16]);
    assign p7 = sx16(cal.press_mid[47:32]);
    assign p8 = sx16(cal.press_mid[63:48]);
    assign p9 = sx16(cal.press_high);

    always_comb
    begin
        logic [35:0] t5;
        logic [27:0] ts;
        logic [63:0] fx;
        fx = {{32{in_item.fine[31]}}, in_item.fine};
        t5 = {{2{in_item.fine[31]}}, in_item.fine, 2'b00}
           + {{4{in_item.fine[31]}}, in_item.fine} + 36'd128;
        ts = t5[35:8];

        pre_next[0]    = '0;
        pre_next[0].a  = fx - C_FINE_OFFSET;
        pre_next[0].pm = C_PRESS_BASE - {44'd0, in_item.adc_press};
        if ($signed(ts) > 28'sd8388607)
        begin
            pre_next[0].tc = 24'h7FFFFF;
        end
        else if ($signed(ts) < -28'sd8388608)
        begin
            pre_next[0].tc = 24'h800000;
        end
        else
        begin
            pre_next[0].tc = ts[23:0];
        end

        pre_next[1]    = pre_reg[0];
        pre_next[1].m0 = mul_part(pre_reg[0].a, pre_reg[0].a);
        pre_next[1].m1 = mul_part(pre_reg[0].a, p5);
        pre_next[1].m2 = mul_part(pre_reg[0].a, p2);

        pre_next[2]     = pre_reg[1];
        pre_next[2].aa  = mul_join(pre_reg[1].m0);
        pre_next[2].ap5 = mul_join(pre_reg[1].m1);
        pre_next[2].ap2 = mul_join(pre_reg[1].m2);

        pre_next[3]    = pre_reg[2];
        pre_next[3].m0 = mul_part(pre_reg[2].aa, p6);
        pre_next[3].m1 = mul_part(pre_reg[2].aa, p3);

        pre_next[4]      = pre_reg[3];
        pre_next[4].aap6 = mul_join(pre_reg[3].m0);
        pre_next[4].aap3 = mul_join(pre_reg[3].m1);

        pre_next[5]    = pre_reg[4];
        pre_next[5].bb = pre_reg[4].aap6 + (pre_reg[4].ap5 << 17) + (p4 << 35);
        pre_next[5].a2 = asr64(pre_reg[4].aap3, 8) + (pre_reg[4].ap2 << 12);

        pre_next[6]   = pre_reg[5];
        pre_next[6].x = C_ONE_Q47 + pre_reg[5].a2;
        pre_next[6].y = (pre_reg[5].pm << 31) - pre_reg[5].bb;

        pre_next[7]    = pre_reg[6];
        pre_next[7].m0 = mul_part(pre_reg[6].x, p1);
        pre_next[7].m1 = mul_part(pre_reg[6].y, C_PRESS_SCALE);

        pre_next[8]   = pre_reg[7];
        pre_next[8].d = asr64(mul_join(pre_reg[7].m0), 33);
        pre_next[8].n = mul_join(pre_reg[7].m1);

        pre_next[9]         = pre_reg[8];
        pre_next[9].invalid = (pre_reg[8].d == '0);
        pre_next[9].neg     = pre_reg[8].d[63] ^ pre_reg[8].n[63];
        pre_next[9].num     = pre_reg[8].n[63] ? -pre_reg[8].n : pre_reg[8].n;
        pre_next[9].den     = pre_reg[8].d[63] ? -pre_reg[8].d : pre_reg[8].d;
        pre_next[9].rem     = '0;
    end

    assign div_in[0] = pre_reg[PRE_STAGES-1];

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_div_link
        assign div_in[k] = div_reg[k-1];
    end

    always_comb
    begin
        post_next[0]   = div_reg[DIV_STAGES-1];
        post_next[0].q = div_reg[DIV_STAGES-1].neg ? -div_reg[DIV_STAGES-1].num
                                                   : div_reg[DIV_STAGES-1].num;

        post_next[1]     = post_reg[0];
        post_next[1].q13 = asr64(post_reg[0].q, 13);
        post_next[1].m0  = mul_part(p9, asr64(post_reg[0].q, 13));
        post_next[1].m1  = mul_part(p8, post_reg[0].q);

        post_next[2]     = post_reg[1];
        post_next[2].r1  = mul_join(post_reg[1].m0);
        post_next[2].b19 = asr64(mul_join(post_reg[1].m1), 19);

        post_next[3]    = post_reg[2];
        post_next[3].m0 = mul_part(post_reg[2].r1, post_reg[2].q13);

        post_next[4]    = post_reg[3];
        post_next[4].r2 = mul_join(post_reg[3].m0);

        post_next[5]     = post_reg[4];
        post_next[5].sum = post_reg[4].q + asr64(post_reg[4].r2, 25) + post_reg[4].b19;

        post_next[6]   = post_reg[5];
        post_next[6].x = asr64(post_reg[5].sum, 8) + (p7 << 4);
        if (post_reg[5].invalid || post_next[6].x[63])
        begin
            post_next[6].pq = '0;
        end
        else if (post_next[6].x[62:32] != '0)
        begin
            post_next[6].pq = 32'hFFFFFFFF;
        end
        else
        begin
            post_next[6].pq = post_next[6].x[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            div_vld_reg  <= '0;
            post_vld_reg <= '0;
        end
        else
        begin
            pre_vld_reg  <= {pre_vld_reg[PRE_STAGES-2:0], in_valid};
            div_vld_reg  <= {div_vld_reg[DIV_STAGES-2:0], pre_vld_reg[PRE_STAGES-1]};
            post_vld_reg <= {post_vld_reg[POST_STAGES-2:0], div_vld_reg[DIV_STAGES-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PRE_STAGES; i++)
        begin
            pre_reg[i] <= pre_next[i];
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            div_reg[i] <= div_step(div_in[i]);
        end
        for (int i = 0; i < POST_STAGES; i++)
        begin
            post_reg[i] <= post_next[i];
        end
    end

    assign done          = post_vld_reg[POST_STAGES-1];
    assign temp_centi    = $signed(post_reg[POST_STAGES-1].tc);
    assign press_q8      = post_reg[POST_STAGES-1].pq;
    assign press_invalid = post_reg[POST_STAGES-1].invalid;

endmodule

// ----- rtl/barometer_raw_compensation_core.sv -----
// ----------------------------------------------------------------------------
// barometer_raw_compensation_core
// Raw temperature and pressure compensation with packed calibration words.
//
// Usage:
//   Load the four calibration registers through cfg_valid/cfg_ready,
//   cfg_index and cfg_data while the core is idle; cfg_ready is always high.
//   Present a reading pair on adc_temp/adc_press with start; it is taken
//   at a clock edge where busy is low.
//   Each request gives one result: done is high for one cycle with
//   temp_centi, press_q8 and press_invalid. The receiver cannot stall.
//   Each accepted request passes through 4 front stages, the queue,
//   10 product stages, 64 divider stages (one quotient bit each) and
//   7 correction stages. Throughput is one request per cycle while busy
//   is low; every stage is a pipeline register, so the divider sets the
//   latency, not the rate.
//   Reset clears the calibration registers to zero and empties the
//   pipeline and the queue; busy is low out of reset.
// ----------------------------------------------------------------------------
module barometer_raw_compensation_core
#(
    parameter int QUEUE_DEPTH = bmpc_pkg::QDEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        adc_temp,
    input  logic [19:0]        adc_press,
    output logic               done,
    output logic signed [23:0] temp_centi,
    output logic [31:0]        press_q8,
    output logic               press_invalid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import bmpc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int IW = $clog2(FRONT_STAGES+1);

    cal_t            cal_reg;
    logic            front_valid;
    item_t           front_item;
    logic [IW-1:0]   inflight;
    logic            q_pop;
    item_t           q_item;
    logic [CW-1:0]   q_fill;
    logic            accept;

    assign cfg_ready = 1'b1;
    assign busy      = (int'(q_fill) + int'(inflight)) >= QUEUE_DEPTH;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CAL_TEMPERATURE:   cal_reg.temp       <= cfg_data[47:0];
                CFG_CAL_PRESSURE_LOW:  cal_reg.press_low  <= cfg_data;
                CFG_CAL_PRESSURE_MID:  cal_reg.press_mid  <= cfg_data;
                CFG_CAL_PRESSURE_HIGH: cal_reg.press_high <= cfg_data[15:0];
                default:               cal_reg            <= cal_reg;
            endcase
        end
    end

    bmpc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .adc_temp  (adc_temp),
        .adc_press (adc_press),
        .cal       (cal_reg),
        .out_valid (front_valid),
        .out_item  (front_item),
        .inflight  (inflight)
    );

    bmpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .fill      (q_fill)
    );

    bmpc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_pop),
        .in_item       (q_item),
        .cal           (cal_reg),
        .done          (done),
        .temp_centi    (temp_centi),
        .press_q8      (press_q8),
        .press_invalid (press_invalid)
    );

endmodule
